// ===== sv/touch_region_hit_table_top_macros.svh =====
// Assertion macros for the touch region hit table.
`ifndef TOUCH_REGION_HIT_TABLE_TOP_MACROS_SVH
`define TOUCH_REGION_HIT_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TRHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trht: assertion failed");
`define TRHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trht: assertion failed");
`else
`define TRHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TRHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/trht_pkg.sv =====
// Shared types, codes and constants of the touch region hit table.
package trht_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COORD_BITS_DEF = 12;
    localparam int COORD_W        = 12;
    localparam int TYPE_W         = 3;
    localparam int HID_W          = 8;
    localparam int COUNT_W        = 5;

    typedef enum logic [1:0] {
        K_REGISTER = 2'd0,
        K_REMOVE   = 2'd1,
        K_CHECK    = 2'd2,
        K_CLEAR    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    localparam logic [TYPE_W-1:0] EV_SWIPE_FIRST = 3'd1;
    localparam logic [TYPE_W-1:0] EV_SWIPE_LAST  = 3'd4;

    typedef struct packed {
        logic load_in;
        logic compare;
        logic apply;
    } t_cmd;

    function automatic logic is_swipe(input logic [TYPE_W-1:0] ev);
        return (ev >= EV_SWIPE_FIRST) && (ev <= EV_SWIPE_LAST);
    endfunction

endpackage

// ===== sv/trht_if.sv =====
// Request and response channel interfaces of the touch region hit table.
interface trht_req_if import trht_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [TYPE_W-1:0]  event_type;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] x_stop;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] y_stop;
    logic [HID_W-1:0]   handler_id;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;

    modport source (
        output valid, kind, event_type, x_start, x_stop, y_start, y_stop,
               handler_id, x_pos, y_pos,
        input  ready
    );
    modport sink (
        input  valid, kind, event_type, x_start, x_stop, y_start, y_stop,
               handler_id, x_pos, y_pos,
        output ready
    );
endinterface

interface trht_rsp_if import trht_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [HID_W-1:0]   handler_out;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;

    modport source (
        output valid, hit, handler_out, status, entry_count,
        input  ready
    );
    modport sink (
        input  valid, hit, handler_out, status, entry_count,
        output ready
    );
endinterface

// ===== sv/trht_ctrl.sv =====
// Sequencer of the touch region hit table: handshakes and compare/apply steps.
module trht_ctrl import trht_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_APPLY) && out_free);
    assign accept     = i_in_valid && o_in_ready;

    assign o_cmd.load_in = accept;
    assign o_cmd.compare = (r_state == S_MATCH);
    assign o_cmd.apply   = (r_state == S_APPLY) && out_free;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = accept ? S_MATCH : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/trht_dp.sv =====
// Datapath of the touch region hit table: entry rows, match flags, result register.
`include "touch_region_hit_table_top_macros.svh"
module trht_dp import trht_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [1:0]         i_kind,
    input  logic [TYPE_W-1:0]  i_event_type,
    input  logic [COORD_W-1:0] i_x_start,
    input  logic [COORD_W-1:0] i_x_stop,
    input  logic [COORD_W-1:0] i_y_start,
    input  logic [COORD_W-1:0] i_y_stop,
    input  logic [HID_W-1:0]   i_handler_id,
    input  logic [COORD_W-1:0] i_x_pos,
    input  logic [COORD_W-1:0] i_y_pos,
    output logic               o_hit,
    output logic [HID_W-1:0]   o_handler_out,
    output logic [1:0]         o_status,
    output logic [COUNT_W-1:0] o_entry_count
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int EXT_W = CNT_W + COUNT_W;

    typedef struct packed {
        logic [TYPE_W-1:0]     etype;
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] xe;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] ye;
        logic [HID_W-1:0]      hid;
    } t_entry;

    t_entry                r_tab [ENTRIES];
    t_entry                r_req;
    t_kind                 r_kind;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic [ENTRIES-1:0]    r_flags;
    logic [ENTRIES-1:0]    n_flags;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_hit;
    logic [HID_W-1:0]      r_hout;
    t_status               r_status;
    t_status               n_status;
    logic [COUNT_W-1:0]    r_ocount;
    logic [EXT_W-1:0]      count_ext;
    logic [IDX_W-1:0]      idx;
    logic                  any;
    logic                  room;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind    <= t_kind'(i_kind);
            r_req.etype <= i_event_type;
            r_req.xs  <= COORD_BITS'(i_x_start);
            r_req.xe  <= COORD_BITS'(i_x_stop);
            r_req.ys  <= COORD_BITS'(i_y_start);
            r_req.ye  <= COORD_BITS'(i_y_stop);
            r_req.hid <= i_handler_id;
            r_px      <= COORD_BITS'(i_x_pos);
            r_py      <= COORD_BITS'(i_y_pos);
        end
    end

    // per-entry compare, masked by fill count
    always_comb begin
        logic same_rect;
        logic in_rect;
        logic cond;
        for (int i = 0; i < ENTRIES; i++) begin
            same_rect = (r_tab[i].etype == r_req.etype) && (r_tab[i].xs == r_req.xs) &&
                        (r_tab[i].xe == r_req.xe) && (r_tab[i].ys == r_req.ys) &&
                        (r_tab[i].ye == r_req.ye);
            in_rect   = (r_px >= r_tab[i].xs) && (r_px <= r_tab[i].xe) &&
                        (r_py >= r_tab[i].ys) && (r_py <= r_tab[i].ye);
            cond = 1'b0;
            case (r_kind)
                K_REGISTER: cond = same_rect;
                K_REMOVE:   cond = same_rect && (r_tab[i].hid == r_req.hid);
                K_CHECK:    cond = (r_tab[i].etype == r_req.etype) &&
                                   (is_swipe(r_tab[i].etype) || in_rect);
                default:    cond = 1'b0;
            endcase
            n_flags[i] = cond && (CNT_W'(i) < r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_flags <= n_flags;
        end
    end

    // first matching entry
    always_comb begin
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_flags[i]) begin
                idx = IDX_W'(i);
            end
        end
    end

    assign any  = |r_flags;
    assign room = r_count < CNT_W'(ENTRIES);

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        unique case (r_kind)
            K_REGISTER: begin
                if (!any) begin
                    if (room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_status = ST_FULL;
                    end
                end
            end
            K_REMOVE: begin
                if (any) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_NO_MATCH;
                end
            end
            K_CHECK: begin
                n_count = r_count;
            end
            K_CLEAR: begin
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            if (r_kind == K_REGISTER) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (any && (idx == IDX_W'(i))) begin
                        r_tab[i].hid <= r_req.hid;
                    end else if (!any && room && (r_count == CNT_W'(i))) begin
                        r_tab[i] <= r_req;
                    end
                end
            end
            if ((r_kind == K_REMOVE) && any) begin
                for (int i = 0; i < ENTRIES - 1; i++) begin
                    if (IDX_W'(i) >= idx) begin
                        r_tab[i] <= r_tab[i + 1];
                    end
                end
            end
        end
    end

    assign count_ext = EXT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_hit    <= (r_kind == K_CHECK) && any;
            r_hout   <= ((r_kind == K_CHECK) && any) ? r_tab[idx].hid : '0;
            r_status <= n_status;
            r_ocount <= count_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.apply) begin
            r_count <= n_count;
        end
    end

    assign o_hit         = r_hit;
    assign o_handler_out = r_hout;
    assign o_status      = r_status;
    assign o_entry_count = r_ocount;

    `TRHT_ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(ENTRIES))
    `TRHT_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, i_cmd.apply && (r_kind == K_CLEAR), r_count == '0)
    `TRHT_ASSERT_NEXT(a_append_grows, i_clk, i_rst_n, i_cmd.apply && (r_kind == K_REGISTER) && !any && room, r_count == $past(r_count) + CNT_W'(1))
    `TRHT_ASSERT_NEXT(a_hit_only_check, i_clk, i_rst_n, i_cmd.apply && (r_kind != K_CHECK), !r_hit && (r_hout == '0))

endmodule

// ===== sv/touch_region_hit_table_top.sv =====
// Top level of the touch region hit table.
//
//   port    | dir | role
//   --------+-----+----------------------------------------------------
//   i_req   | in  | item: register, remove, check or clear
//   o_rsp   | out | one result per item: hit, handler, status, count
//
// An item passes a compare step, which checks all rows in parallel into a
// registered flag vector, then an apply step, which selects the first flag and
// updates the rows. The next item can be taken during the current apply step.
// Reset clears the sequencer, result valid and fill count; rows stay undefined.
// The apply step waits while an earlier result is still held in the output
// register; no new item is taken until the apply step completes.
module touch_region_hit_table_top import trht_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    trht_req_if.sink        i_req,
    trht_rsp_if.source      o_rsp
);

    t_cmd cmd;

    trht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    trht_dp #(
        .ENTRIES    (ENTRIES),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_kind        (i_req.kind),
        .i_event_type  (i_req.event_type),
        .i_x_start     (i_req.x_start),
        .i_x_stop      (i_req.x_stop),
        .i_y_start     (i_req.y_start),
        .i_y_stop      (i_req.y_stop),
        .i_handler_id  (i_req.handler_id),
        .i_x_pos       (i_req.x_pos),
        .i_y_pos       (i_req.y_pos),
        .o_hit         (o_rsp.hit),
        .o_handler_out (o_rsp.handler_out),
        .o_status      (o_rsp.status),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule

// ===== test/tb.sv =====
// Testbench for the touch region hit table: queued driver, table predictor, result checker.
module tb;
    import trht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH  = ENTRIES_DEF;
    localparam int RAND_ITEMS = 1720;
    localparam int RUN_LIMIT  = 600000;
    localparam int GEN_VIEW   = 0;
    localparam int LIVE_VIEW  = 1;
    localparam int COORD_MAX  = (1 << COORD_W) - 1;

    localparam logic [TYPE_W-1:0] EV_NONE   = 3'd0;
    localparam logic [TYPE_W-1:0] EV_UP     = 3'd1;
    localparam logic [TYPE_W-1:0] EV_DOWN   = 3'd2;
    localparam logic [TYPE_W-1:0] EV_LEFT   = 3'd3;
    localparam logic [TYPE_W-1:0] EV_RIGHT  = 3'd4;
    localparam logic [TYPE_W-1:0] EV_CLICK  = 3'd5;
    localparam logic [TYPE_W-1:0] EV_DOUBLE = 3'd6;
    localparam logic [TYPE_W-1:0] EV_LONG   = 3'd7;

    typedef struct packed {
        logic [TYPE_W-1:0]  ev;
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] ys;
        logic [COORD_W-1:0] ye;
        logic [HID_W-1:0]   hid;
    } t_region;

    typedef struct packed {
        t_kind              kind;
        t_region            reg_f;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        bit                 hold;
    } t_touch_item;

    typedef struct packed {
        logic               hit;
        logic [HID_W-1:0]   hout;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_touch_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    trht_req_if req_ch ();
    trht_rsp_if rsp_ch ();

    touch_region_hit_table_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // two copies of the table: one tracks generation, one tracks accepted items
    t_region     tbl_rows [2][TBL_DEPTH];
    int          tbl_used [2] = '{0, 0};

    t_touch_item queued_touches [$];
    t_touch_rsp  pending_answers [$];
    t_touch_item on_wire;

    int  errors   = 0;
    int  accepted = 0;
    int  answered = 0;
    int  n_hits   = 0;
    int  n_full   = 0;
    int  n_nomatch = 0;
    int  n_kind [4] = '{0, 0, 0, 0};
    int  tx_gap   = 0;
    int  rx_gap   = 0;
    bit  calm_tx  = 1'b0;
    bit  calm_rx  = 1'b0;
    int  cycles   = 0;

    function automatic bit same_region(t_region a, t_region b);
        return a.ev == b.ev && a.xs == b.xs && a.xe == b.xe && a.ys == b.ys && a.ye == b.ye;
    endfunction

    function automatic t_touch_rsp apply_touch_item(int s, t_touch_item it);
        t_touch_rsp r;
        int         n;
        int         k;
        r = '{hit: 1'b0, hout: '0, status: ST_OK, count: '0};
        n = tbl_used[s];
        k = -1;
        case (it.kind)
            K_REGISTER: begin
                for (int i = 0; i < n; i++)
                    if (k < 0 && same_region(tbl_rows[s][i], it.reg_f)) k = i;
                if (k >= 0) begin
                    tbl_rows[s][k].hid = it.reg_f.hid;
                end else if (n < TBL_DEPTH) begin
                    tbl_rows[s][n] = it.reg_f;
                    n++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            K_REMOVE: begin
                for (int i = 0; i < n; i++)
                    if (k < 0 && tbl_rows[s][i] == it.reg_f) k = i;
                if (k < 0) begin
                    r.status = ST_NO_MATCH;
                end else begin
                    for (int i = k; i < n - 1; i++) tbl_rows[s][i] = tbl_rows[s][i + 1];
                    n--;
                end
            end
            K_CHECK: begin
                for (int i = 0; i < n; i++) begin
                    if (!r.hit && tbl_rows[s][i].ev == it.reg_f.ev &&
                        ((it.reg_f.ev >= EV_SWIPE_FIRST && it.reg_f.ev <= EV_SWIPE_LAST) ||
                         (it.px >= tbl_rows[s][i].xs && it.px <= tbl_rows[s][i].xe &&
                          it.py >= tbl_rows[s][i].ys && it.py <= tbl_rows[s][i].ye))) begin
                        r.hit  = 1'b1;
                        r.hout = tbl_rows[s][i].hid;
                    end
                end
            end
            default: n = 0;
        endcase
        tbl_used[s] = n;
        r.count = n[COUNT_W-1:0];
        return r;
    endfunction

    function automatic t_touch_item mk(t_kind kind, logic [TYPE_W-1:0] ev,
                                       int xs, int xe, int ys, int ye, int hid,
                                       int px, int py);
        t_touch_item it;
        it.kind  = kind;
        it.reg_f = '{ev: ev, xs: xs[COORD_W-1:0], xe: xe[COORD_W-1:0],
                     ys: ys[COORD_W-1:0], ye: ye[COORD_W-1:0], hid: hid[HID_W-1:0]};
        it.px    = px[COORD_W-1:0];
        it.py    = py[COORD_W-1:0];
        it.hold  = 1'b0;
        return it;
    endfunction

    function automatic void push_item(t_touch_item it);
        t_touch_rsp unused;
        queued_touches.push_back(it);
        unused = apply_touch_item(GEN_VIEW, it);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, COORD_MAX));
    endfunction

    function automatic t_region rand_region();
        t_region g;
        int      r;
        int      lo;
        r = int'($urandom_range(0, 9));
        g.ev  = TYPE_W'($urandom_range(0, 7));
        g.hid = HID_W'($urandom_range(0, 255));
        if (r == 0) begin
            g.xs = COORD_W'(rand_coord()); g.xe = COORD_W'(rand_coord());
            g.ys = COORD_W'(rand_coord()); g.ye = COORD_W'(rand_coord());
        end else if (r == 1) begin
            g.xs = '0; g.xe = COORD_W'(COORD_MAX); g.ys = '0; g.ye = COORD_W'(COORD_MAX);
        end else begin
            lo = rand_coord();
            g.xs = COORD_W'(lo);
            g.xe = COORD_W'($urandom_range(lo, COORD_MAX));
            lo = rand_coord();
            g.ys = COORD_W'(lo);
            g.ye = COORD_W'($urandom_range(lo, COORD_MAX));
        end
        return g;
    endfunction

    function automatic int pick_between(int lo, int hi);
        int r;
        r = int'($urandom_range(0, 3));
        if (lo > hi) return rand_coord();
        if (r == 0) return lo;
        if (r == 1) return hi;
        return int'($urandom_range(lo, hi));
    endfunction

    function automatic t_touch_item rand_item();
        t_touch_item it;
        t_region     e;
        int          pick;
        int          n;
        int          b;
        n    = tbl_used[GEN_VIEW];
        pick = int'($urandom_range(0, 99));
        if (n == 0 && pick >= 30 && pick < 85) pick = 0;
        it = mk(t_kind'($urandom_range(0, 3)), TYPE_W'($urandom_range(0, 7)), rand_coord(),
                rand_coord(), rand_coord(), rand_coord(), int'($urandom_range(0, 255)),
                rand_coord(), rand_coord());
        if (n > 0) e = tbl_rows[GEN_VIEW][$urandom_range(0, n - 1)];
        if (pick < 30) begin
            it.kind  = K_REGISTER;
            it.reg_f = rand_region();
        end else if (pick < 40) begin
            it.kind      = K_REGISTER;
            it.reg_f     = e;
            it.reg_f.hid = HID_W'($urandom_range(0, 255));
        end else if (pick < 55) begin
            it.kind  = K_REMOVE;
            it.reg_f = e;
        end else if (pick < 60) begin
            // near miss: one bit off in an otherwise exact remove
            it.kind  = K_REMOVE;
            b        = int'($urandom_range(0, $bits(t_region) - 1));
            it.reg_f = e ^ (t_region'(1) << b);
        end else if (pick < 85) begin
            it.kind     = K_CHECK;
            it.reg_f.ev = e.ev;
            it.px       = COORD_W'(pick_between(int'(e.xs), int'(e.xe)));
            it.py       = COORD_W'(pick_between(int'(e.ys), int'(e.ye)));
        end else if (pick < 95) begin
            it.kind = K_CHECK;
        end else if (pick < 97) begin
            it.kind = K_CLEAR;
        end
        return it;
    endfunction

    function automatic int draw_gap(bit calm);
        int r;
        if (calm) return 0;
        r = int'($urandom_range(0, 99));
        if (r < 55) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    always @(posedge i_clk) begin : feed_proc
        bit         go;
        t_touch_rsp r;
        go = 1'b0;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) calm_tx = !calm_tx;
            if (req_ch.valid && req_ch.ready) begin
                r = apply_touch_item(LIVE_VIEW, on_wire);
                pending_answers.push_back(r);
                accepted++;
                n_kind[on_wire.kind]++;
                if (r.hit) n_hits++;
                if (r.status == ST_FULL) n_full++;
                if (r.status == ST_NO_MATCH) n_nomatch++;
                tx_gap = draw_gap(calm_tx);
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (queued_touches.size() > 0 &&
                             !(queued_touches[0].hold && pending_answers.size() > 0)) begin
                    on_wire = queued_touches.pop_front();
                    go      = 1'b1;
                    req_ch.kind       <= on_wire.kind;
                    req_ch.event_type <= on_wire.reg_f.ev;
                    req_ch.x_start    <= on_wire.reg_f.xs;
                    req_ch.x_stop     <= on_wire.reg_f.xe;
                    req_ch.y_start    <= on_wire.reg_f.ys;
                    req_ch.y_stop     <= on_wire.reg_f.ye;
                    req_ch.handler_id <= on_wire.reg_f.hid;
                    req_ch.x_pos      <= on_wire.px;
                    req_ch.y_pos      <= on_wire.py;
                end
                req_ch.valid <= go;
            end
        end
    end

    task automatic flag_field(string name, logic [HID_W-1:0] want, logic [HID_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : watch_proc
        t_touch_rsp want;
        int         g;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                answered++;
                if (pending_answers.size() == 0) begin
                    $display("%0t: unexpected result, expected none got hit %0b handler %0h",
                             $time, rsp_ch.hit, rsp_ch.handler_out);
                    errors++;
                end else begin
                    want = pending_answers.pop_front();
                    flag_field("hit", HID_W'(want.hit), HID_W'(rsp_ch.hit));
                    flag_field("handler_out", want.hout, rsp_ch.handler_out);
                    flag_field("status", HID_W'(want.status), HID_W'(rsp_ch.status));
                    flag_field("entry_count", HID_W'(want.count), HID_W'(rsp_ch.entry_count));
                end
            end
            if ($urandom_range(0, 199) == 0) calm_rx = !calm_rx;
            if (rx_gap > 0) begin
                rx_gap--;
                rsp_ch.ready <= 1'b0;
            end else begin
                g = draw_gap(calm_rx);
                rsp_ch.ready <= (g == 0);
                if (g > 0) rx_gap = g - 1;
            end
        end
    end

    initial begin : watchdog
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : main
        t_touch_item it;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = K_CLEAR;
        req_ch.event_type = '0;
        req_ch.x_start    = '0;
        req_ch.x_stop     = '0;
        req_ch.y_start    = '0;
        req_ch.y_stop     = '0;
        req_ch.handler_id = '0;
        req_ch.x_pos      = '0;
        req_ch.y_pos      = '0;
        rsp_ch.ready      = 1'b0;

        // directed: empty table, extremes, replace, inverted rectangles, full table
        push_item(mk(K_CHECK, EV_CLICK, 0, 0, 0, 0, 0, 0, 0));
        push_item(mk(K_REMOVE, EV_NONE, 0, 0, 0, 0, 0, 0, 0));
        push_item(mk(K_CLEAR, EV_NONE, 0, 0, 0, 0, 0, 0, 0));
        push_item(mk(K_REGISTER, EV_NONE, 0, COORD_MAX, 0, COORD_MAX, 0, 0, 0));
        push_item(mk(K_CHECK, EV_NONE, 0, 0, 0, 0, 0, COORD_MAX, COORD_MAX));
        push_item(mk(K_REGISTER, EV_UP, COORD_MAX, 0, COORD_MAX, 0, 255, 0, 0));
        push_item(mk(K_CHECK, EV_UP, 0, 0, 0, 0, 0, 0, COORD_MAX));
        push_item(mk(K_REGISTER, EV_CLICK, COORD_MAX, 0, COORD_MAX, 0, 1, 0, 0));
        push_item(mk(K_CHECK, EV_CLICK, 0, 0, 0, 0, 0, 2048, 2048));
        push_item(mk(K_REGISTER, EV_NONE, 0, COORD_MAX, 0, COORD_MAX, 'hAA, 0, 0));
        push_item(mk(K_CHECK, EV_NONE, 0, 0, 0, 0, 0, 0, 0));
        push_item(mk(K_REMOVE, EV_NONE, 0, COORD_MAX, 0, COORD_MAX, 'h55, 0, 0));
        push_item(mk(K_REGISTER, EV_DOWN, 100, 200, 300, 400, 2, 0, 0));
        push_item(mk(K_REGISTER, EV_LEFT, 5, 5, 7, 7, 3, 0, 0));
        push_item(mk(K_REGISTER, EV_RIGHT, 0, 0, 0, 0, 4, 0, 0));
        push_item(mk(K_REGISTER, EV_DOUBLE, 10, 20, 10, 20, 6, 0, 0));
        push_item(mk(K_REGISTER, EV_LONG, 1000, 3000, 2000, 2500, 7, 0, 0));
        push_item(mk(K_CHECK, EV_LONG, 0, 0, 0, 0, 0, 3000, 2000));
        push_item(mk(K_CHECK, EV_DOUBLE, 0, 0, 0, 0, 0, 21, 15));
        push_item(mk(K_REMOVE, EV_UP, COORD_MAX, 0, COORD_MAX, 0, 255, 0, 0));
        push_item(mk(K_CHECK, EV_UP, 0, 0, 0, 0, 0, 1, 1));
        while (tbl_used[GEN_VIEW] < TBL_DEPTH) begin
            it = mk(K_REGISTER, EV_CLICK, 0, 0, 0, 0, 0, 0, 0);
            it.reg_f = rand_region();
            push_item(it);
        end
        push_item(mk(K_REGISTER, EV_CLICK, 1, 2, 3, 4, 9, 0, 0));
        push_item(mk(K_REGISTER, EV_NONE, 0, COORD_MAX, 0, COORD_MAX, 'h11, 0, 0));
        push_item(mk(K_CHECK, EV_NONE, 0, 0, 0, 0, 0, 17, 4000));
        push_item(mk(K_CLEAR, EV_NONE, 0, 0, 0, 0, 0, 0, 0));

        for (int k = 0; k < RAND_ITEMS; k++) begin
            it = rand_item();
            if (k == 0 || k == RAND_ITEMS / 2) it.hold = 1'b1;
            push_item(it);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_touches.size() > 0 || req_ch.valid || pending_answers.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d items (register %0d, remove %0d, check %0d, clear %0d), %0d results",
                 accepted, n_kind[K_REGISTER], n_kind[K_REMOVE], n_kind[K_CHECK],
                 n_kind[K_CLEAR], answered);
        $display("%0d check hits, %0d table-full answers, %0d removes without match",
                 n_hits, n_full, n_nomatch);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
